// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the console writer controller. The checks compile
// only in simulation and vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is high.
`define TCW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCW_ASSERT(label, clk, rst, prop, msg)
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, constants and codes shared by the text console writer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths of the request and result channels.
  localparam int OP_W        = 1;
  localparam int CHAR_W      = 8;
  localparam int ADDR_FLD_W  = 11;
  localparam int CELL_W      = 16;
  localparam int ROW_FLD_W   = 5;
  localparam int COL_FLD_W   = 7;
  localparam int ATTR_W      = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
  localparam logic [OP_W-1:0] OP_READ = 1'b1;

  // Character codes with special meaning.
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  // Reset contents of the screen and reset attribute.
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_BLANK,
    ST_RESULT
  } tcw_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_load;
    logic cnt_zero;
    logic cnt_inc;
    logic mem_clear;
    logic mem_put;
    logic mem_copy;
    logic mem_blank;
    logic col_zero;
    logic col_inc;
    logic row_inc;
    logic cursor_load;
    logic out_load;
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] item_op;
    logic            is_newline;
    logic            is_return;
    logic            col_last;
    logic            row_last;
    logic            clear_end;
    logic            copy_end;
    logic            blank_end;
  } tcw_status_t;

endpackage

`default_nettype wire

// ----- rtl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, write position, hardware cursor, attribute register,
// sweep counter and result registers of the console writer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tcw_pkg::tcw_cmd_t              cmd,
  input  wire logic                           cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0]     cfg_data,
  input  wire logic [tcw_pkg::OP_W-1:0]       op,
  input  wire logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  wire logic [tcw_pkg::ADDR_FLD_W-1:0] cell_address,
  output tcw_pkg::tcw_status_t                status,
  output logic      [tcw_pkg::CELL_W-1:0]     cell_data,
  output logic      [tcw_pkg::ADDR_FLD_W-1:0] cursor_index,
  output logic      [tcw_pkg::ROW_FLD_W-1:0]  cursor_row,
  output logic      [tcw_pkg::COL_FLD_W-1:0]  cursor_col
);

  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  logic [OP_W-1:0]       item_op;
  logic [CHAR_W-1:0]     item_char;
  logic [ADDR_FLD_W-1:0] item_addr;
  logic [ATTR_W-1:0]     attr;
  logic [ROW_W-1:0]      row;
  logic [COL_W-1:0]      col;
  logic [ADDR_FLD_W-1:0] cursor;
  logic [ADDR_FLD_W-1:0] cursor_next;
  logic [CNT_W-1:0]      cnt;

  logic [31:0]           lin32;
  logic [31:0]           addr32;
  logic [31:0]           cnt32;
  logic [31:0]           src32;
  logic [31:0]           dst32;
  logic [31:0]           blank32;
  logic [31:0]           row32;
  logic [31:0]           col32;
  logic                  in_range;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [CELL_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [CELL_W-1:0]     ram_q;

  // Address arithmetic, all in a common 32-bit frame.
  always_comb begin
    row32    = 32'(row);
    col32    = 32'(col);
    lin32    = row32 * 32'(COLUMNS) + col32;
    addr32   = 32'(item_addr);
    cnt32    = 32'(cnt);
    src32    = cnt32 + 32'(COLUMNS);
    dst32    = cnt32 - 32'd1;
    blank32  = 32'(CELLS - COLUMNS) + cnt32;
    in_range = addr32 < 32'(CELLS);
  end

  // Memory port selection for puts, reads, clearing, scrolling and blanking.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lin32[ADDR_W-1:0];
    ram_wdata = {attr, item_char};
    ram_raddr = addr32[ADDR_W-1:0];
    if (cmd.mem_clear) begin
      ram_we    = 1'b1;
      ram_waddr = cnt32[ADDR_W-1:0];
      ram_wdata = BLANK_CELL;
    end else if (cmd.mem_put) begin
      ram_we    = 1'b1;
    end else if (cmd.mem_copy) begin
      // Read one row below, write the cell read in the previous cycle.
      ram_raddr = src32[ADDR_W-1:0];
      ram_we    = (cnt != '0);
      ram_waddr = dst32[ADDR_W-1:0];
      ram_wdata = ram_q;
    end else if (cmd.mem_blank) begin
      ram_we    = 1'b1;
      ram_waddr = blank32[ADDR_W-1:0];
      ram_wdata = {attr, CH_SPACE};
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // The cursor register follows the write position when told to.
  assign cursor_next = cmd.cursor_load ? lin32[ADDR_FLD_W-1:0] : cursor;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_op   <= op;
      item_char <= char_code;
      item_addr <= cell_address;
    end
  end

  // Attribute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_we) begin
      attr <= cfg_data;
    end
  end

  // Write position and hardware cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      col    <= '0;
      cursor <= '0;
    end else begin
      if (cmd.col_zero) begin
        col <= '0;
      end else if (cmd.col_inc) begin
        col <= col + COL_W'(1);
      end
      if (cmd.row_inc) begin
        row <= row + ROW_W'(1);
      end
      cursor <= cursor_next;
    end
  end

  // Sweep counter for clearing, copying and blanking.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_zero) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_data    <= (item_op == OP_READ && in_range) ? ram_q : '0;
      cursor_index <= cursor_next;
      cursor_row   <= row32[ROW_FLD_W-1:0];
      cursor_col   <= col32[COL_FLD_W-1:0];
    end
  end

  // Status toward the controller.
  always_comb begin
    status.item_op    = item_op;
    status.is_newline = (item_char == CH_NEWLINE);
    status.is_return  = (item_char == CH_RETURN);
    status.col_last   = (col == COL_W'(COLUMNS - 1));
    status.row_last   = (row == ROW_W'(ROWS - 1));
    status.clear_end  = (cnt32 == 32'(CELLS - 1));
    status.copy_end   = (cnt32 == 32'(CELLS - COLUMNS));
    status.blank_end  = (cnt32 == 32'(COLUMNS - 1));
  end

endmodule

`default_nettype wire

// ----- rtl/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller of the console writer: sequences the clearing pass, request
// execution, scrolling and delivery of each result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire tcw_pkg::tcw_status_t status,
  output tcw_pkg::tcw_cmd_t         cmd
);

  import tcw_pkg::*;

  tcw_state_t state;
  tcw_state_t state_next;
  logic       cur_pend;
  logic       cur_pend_next;
  logic       out_valid_next;

  // State, pending cursor update and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cur_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_pend  <= cur_pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cur_pend_next = cur_pend;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.mem_clear = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (status.clear_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.item_op == OP_READ) begin
          state_next = ST_RESULT;
        end else if (status.is_newline) begin
          cmd.col_zero = 1'b1;
          if (status.row_last) begin
            cmd.cnt_zero  = 1'b1;
            cur_pend_next = 1'b1;
            state_next    = ST_SCROLL;
          end else begin
            cmd.row_inc = 1'b1;
            state_next  = ST_RESULT;
          end
        end else if (status.is_return) begin
          cmd.col_zero = 1'b1;
          state_next   = ST_RESULT;
        end else begin
          // Printed character: store it, then advance and maybe wrap.
          cmd.mem_put   = 1'b1;
          cur_pend_next = 1'b1;
          if (status.col_last) begin
            cmd.col_zero = 1'b1;
            if (status.row_last) begin
              cmd.cnt_zero = 1'b1;
              state_next   = ST_SCROLL;
            end else begin
              cmd.row_inc = 1'b1;
              state_next  = ST_RESULT;
            end
          end else begin
            cmd.col_inc = 1'b1;
            state_next  = ST_RESULT;
          end
        end
      end
      ST_SCROLL: begin
        cmd.mem_copy = 1'b1;
        if (status.copy_end) begin
          cmd.cnt_zero = 1'b1;
          state_next   = ST_BLANK;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_BLANK: begin
        cmd.mem_blank = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (status.blank_end) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        cmd.cursor_load = cur_pend;
        if (!out_valid || !out_stall) begin
          cmd.out_load  = 1'b1;
          cur_pend_next = 1'b0;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Output valid is set by a new result and cleared when the result is taken.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // A new result never overwrites one that is still waiting.
  `TCW_ASSERT(a_no_overwrite, clk, rst, cmd.out_load |-> (!out_valid || !out_stall), "result overwritten")
  // An accepted request is executed in the next cycle.
  `TCW_ASSERT(a_accept_exec, clk, rst, (in_valid && !in_stall) |=> (state == ST_EXEC), "request not executed")
  // A scroll always ends with a cursor update.
  `TCW_ASSERT(a_scroll_cursor, clk, rst, (state == ST_SCROLL || state == ST_BLANK) |-> cur_pend, "scroll without cursor update")
  // No request is taken during the clearing pass.
  `TCW_ASSERT_ALWAYS(a_clear_stall, clk, (!rst && state == ST_CLEAR) |-> in_stall, "request taken while clearing")

endmodule

`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine for a COLUMNS by ROWS screen of 16-bit cells.
// ----------------------------------------------------------------------------
// After reset the block fills the screen memory with attribute-07 blanks and
// accepts no request in that time; attribute writes are taken at any time. A
// request is then latched, executed against the screen memory, and its result
// is handed to the output register before the next request is accepted. A put
// that moves past the last row first scrolls the screen: the copy moves one
// cell per cycle through the single write port of the screen memory, then the
// bottom row is blanked one cell per cycle. A result waiting in the output
// register does not block the next request; only the delivery of the following
// result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Attribute write channel.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcw_pkg::ATTR_W-1:0]     text_attribute,
  // Request channel.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tcw_pkg::OP_W-1:0]       op,
  input  wire logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  wire logic [tcw_pkg::ADDR_FLD_W-1:0] cell_address,
  // Result channel.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [tcw_pkg::CELL_W-1:0]     cell_data,
  output logic      [tcw_pkg::ADDR_FLD_W-1:0] cursor_index,
  output logic      [tcw_pkg::ROW_FLD_W-1:0]  cursor_row,
  output logic      [tcw_pkg::COL_FLD_W-1:0]  cursor_col
);

  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t status;

  // The attribute register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (text_attribute),
    .op           (op),
    .char_code    (char_code),
    .cell_address (cell_address),
    .status       (status),
    .cell_data    (cell_data),
    .cursor_index (cursor_index),
    .cursor_row   (cursor_row),
    .cursor_col   (cursor_col)
  );

endmodule

`default_nettype wire

// ----- test/tb_text_console_writer.sv -----
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. Requests are sent through
// the valid/stall channel and each result is compared field by field with a
// behavioral screen model kept inside the bench. Directed requests cover the
// field extremes, both operations, control characters, reads past the screen
// and both kinds of scroll. Random traffic then runs under several idle and
// stall patterns, with the text attribute changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLS         = DEF_COLUMNS;
  localparam int ROWS         = DEF_ROWS;
  localparam int CELLS        = COLS * ROWS;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int DRAIN_CYCLES = 20;

  // One result of the console, as it appears on the output ports.
  typedef struct packed {
    logic [CELL_W-1:0]     cell_value;
    logic [ADDR_FLD_W-1:0] cursor;
    logic [ROW_FLD_W-1:0]  row;
    logic [COL_FLD_W-1:0]  col;
  } console_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [ATTR_W-1:0]     text_attribute = ATTR_RESET;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       op = OP_PUT;
  logic [CHAR_W-1:0]     char_code = '0;
  logic [ADDR_FLD_W-1:0] cell_address = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CELL_W-1:0]     cell_data;
  logic [ADDR_FLD_W-1:0] cursor_index;
  logic [ROW_FLD_W-1:0]  cursor_row;
  logic [COL_FLD_W-1:0]  cursor_col;

  // Screen model and its write position, cursor and attribute.
  logic [CELL_W-1:0]     screen_model [CELLS];
  int                    pos_row = 0;
  int                    pos_col = 0;
  logic [ADDR_FLD_W-1:0] cursor_reg = '0;
  logic [ATTR_W-1:0]     cur_attr = ATTR_RESET;

  // Console results still to come, oldest first.
  console_result_t       console_results_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int put_count      = 0;
  int read_count     = 0;
  int scroll_count   = 0;
  int attr_writes    = 0;

  text_console_writer u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .text_attribute (text_attribute),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .char_code      (char_code),
    .cell_address   (cell_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cell_data      (cell_data),
    .cursor_index   (cursor_index),
    .cursor_row     (cursor_row),
    .cursor_col     (cursor_col)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Move to column 0 of the next row, scrolling when the last row is passed.
  function automatic void advance_row();
    pos_col = 0;
    pos_row++;
    if (pos_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = {cur_attr, CH_SPACE};
      pos_row = ROWS - 1;
      cursor_reg = ADDR_FLD_W'(pos_row * COLS);
      scroll_count++;
    end
  endfunction

  // Apply one accepted request to the screen model and return its result.
  function automatic console_result_t console_step(input logic [OP_W-1:0] kind,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [ADDR_FLD_W-1:0] addr);
    console_result_t res;
    res = '0;
    if (kind == OP_READ) begin
      read_count++;
      if (addr < CELLS) res.cell_value = screen_model[addr];
    end else begin
      put_count++;
      if (ch == CH_NEWLINE) begin
        advance_row();
      end else if (ch == CH_RETURN) begin
        pos_col = 0;
      end else begin
        screen_model[pos_row * COLS + pos_col] = {cur_attr, ch};
        pos_col++;
        if (pos_col >= COLS) advance_row();
        cursor_reg = ADDR_FLD_W'(pos_row * COLS + pos_col);
      end
    end
    res.cursor = cursor_reg;
    res.row    = pos_row[ROW_FLD_W-1:0];
    res.col    = pos_col[COL_FLD_W-1:0];
    return res;
  endfunction

  // Send one request and record its expected result once it is accepted.
  // Valid stays high afterwards so back-to-back requests need no re-raise.
  task automatic send_request(input logic [OP_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                              input logic [ADDR_FLD_W-1:0] addr);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    char_code    <= ch;
    cell_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    console_results_q.push_back(console_step(kind, ch, addr));
  endtask

  // Drop valid and wait until every outstanding result has been checked.
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (console_results_q.size() != 0) @(posedge clk);
  endtask

  // Write the attribute register; only called while the console is idle.
  task automatic write_attribute(input logic [ATTR_W-1:0] attr);
    cfg_valid      <= 1'b1;
    text_attribute <= attr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_attr = attr;
    attr_writes++;
  endtask

  // Field extremes, both operations, control characters and reads off screen.
  task automatic test_directed_edges();
    send_request(OP_READ, 8'h00, 11'd0);
    send_request(OP_READ, 8'hFF, 11'd1999);
    send_request(OP_READ, 8'h00, 11'd2000);
    send_request(OP_READ, 8'h00, 11'h7FF);
    send_request(OP_PUT, 8'h41, 11'h7FF);
    send_request(OP_PUT, 8'h00, 11'd0);
    send_request(OP_PUT, 8'hFF, 11'd0);
    send_request(OP_PUT, 8'h80, 11'd0);
    send_request(OP_PUT, CH_RETURN, 11'd0);
    send_request(OP_PUT, 8'h7E, 11'd0);
    send_request(OP_PUT, CH_NEWLINE, 11'd0);
    send_request(OP_PUT, CH_SPACE, 11'd0);
    for (int i = 0; i < 4; i++) send_request(OP_READ, 8'h00, ADDR_FLD_W'(i));
    send_request(OP_READ, 8'h00, 11'(COLS));
    finish_phase();
  endtask

  // Walk down to the last row with newlines, then scroll with one more.
  task automatic test_newline_scroll();
    while (pos_row != ROWS - 1) send_request(OP_PUT, CH_NEWLINE, '0);
    for (int i = 0; i < 4; i++) send_request(OP_PUT, CHAR_W'($urandom_range(33, 126)), '0);
    send_request(OP_PUT, CH_NEWLINE, '0);
    for (int i = 0; i < 5; i++) begin
      send_request(OP_READ, 8'h00, ADDR_FLD_W'((ROWS - 2) * COLS + i));
    end
    send_request(OP_READ, 8'h00, ADDR_FLD_W'((ROWS - 1) * COLS));
    finish_phase();
  endtask

  // Fill the whole last row so that the final character wraps and scrolls.
  task automatic test_wrap_scroll();
    send_request(OP_PUT, CH_RETURN, '0);
    for (int i = 0; i < COLS; i++) send_request(OP_PUT, CHAR_W'($urandom_range(14, 255)), '0);
    send_request(OP_READ, 8'h00, ADDR_FLD_W'((ROWS - 2) * COLS));
    send_request(OP_READ, 8'h00, ADDR_FLD_W'((ROWS - 1) * COLS - 1));
    send_request(OP_READ, 8'h00, ADDR_FLD_W'((ROWS - 1) * COLS));
    send_request(OP_READ, 8'h00, ADDR_FLD_W'(CELLS - 1));
    finish_phase();
  endtask

  // Random text stream with reads, mostly near the current write position.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int count);
    int pick;
    int row;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        row = pos_row;
        if (row > 0 && $urandom_range(0, 1) == 1) row--;
        if (pick < 11) begin
          send_request(OP_READ, CHAR_W'($urandom), ADDR_FLD_W'($urandom_range(0, 2047)));
        end else begin
          send_request(OP_READ, CHAR_W'($urandom),
                       ADDR_FLD_W'(row * COLS + $urandom_range(0, COLS - 1)));
        end
      end else if (pick < 39) begin
        send_request(OP_PUT, CH_NEWLINE, ADDR_FLD_W'($urandom));
      end else if (pick < 42) begin
        send_request(OP_PUT, CH_RETURN, ADDR_FLD_W'($urandom));
      end else begin
        send_request(OP_PUT, CHAR_W'($urandom_range(0, 255)), ADDR_FLD_W'($urandom));
      end
    end
    finish_phase();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver stalls at random while a stall rate is set.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Compare every delivered result with the oldest expected one.
  always @(posedge clk) begin
    console_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (console_results_q.size() == 0) begin
        $display("%0t: result with none expected: cell %h cursor %0d row %0d col %0d",
                 $time, cell_data, cursor_index, cursor_row, cursor_col);
        error_count++;
      end else begin
        want = console_results_q.pop_front();
        if (cell_data !== want.cell_value) begin
          $display("%0t: cell_data expected %h actual %h", $time, want.cell_value,
                   cell_data);
          error_count++;
        end
        if (cursor_index !== want.cursor) begin
          $display("%0t: cursor_index expected %0d actual %0d",
                   $time, want.cursor, cursor_index);
          error_count++;
        end
        if (cursor_row !== want.row) begin
          $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, cursor_row);
          error_count++;
        end
        if (cursor_col !== want.col) begin
          $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, cursor_col);
          error_count++;
        end
      end
    end
  end

  // Watchdog against a hung console.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    foreach (screen_model[i]) screen_model[i] = BLANK_CELL;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_newline_scroll();
    write_attribute(8'h00);
    test_wrap_scroll();
    write_attribute(8'hFF);
    test_random_traffic(0, 0, 200);
    write_attribute(ATTR_W'($urandom_range(0, 255)));
    test_random_traffic(46, 0, 200);
    write_attribute(8'h1E);
    test_random_traffic(0, 46, 200);
    write_attribute(8'h5A);
    test_random_traffic(33, 33, 200);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d puts, %0d reads and %0d scrolls under %0d attribute settings.",
             put_count, read_count, scroll_count, attr_writes + 1);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
